[rtl/core/idli_pkg.sv]
// Package of the inverse distance table interpolator: action codes, register indexes,
// fixed point limits, divider steps, state encoding and the structs between modules.
// Used by idli_div, the top level and the testbench; depends on nothing.
package idli_pkg;

	typedef enum logic [1:0] {
		ACT_WR_POINT = 2'd0,
		ACT_WR_PARAM = 2'd1,
		ACT_QUERY    = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	localparam logic CFG_IDX_ENABLE = 1'b0;
	localparam logic CFG_IDX_COUNT  = 1'b1;

	localparam logic [32:0] SUM_EPS    = 33'd6;
	localparam logic [61:0] SNAP_D2    = 62'd115292150;
	localparam logic [61:0] W_SAT_D2   = 62'h0000_0000_8000_0000;
	localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;
	localparam logic [63:0] WEIGHT_NUM = 64'h8000_0000_0000_0000;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	localparam logic [6:0] STEPS_NORM   = 7'd31;
	localparam logic [6:0] STEPS_WEIGHT = 7'd32;
	localparam logic [6:0] STEPS_FINAL  = 7'd32;

	localparam logic [3:0] LAST_SLOT = 4'd7;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ,
		S_NF_GO,
		S_NF_WAIT,
		S_NA_GO,
		S_NA_WAIT,
		S_SQ_F,
		S_SQ_A,
		S_D2,
		S_W_GO,
		S_W_WAIT,
		S_MUL,
		S_ADD,
		S_SNAP,
		S_FIN,
		S_FIN_WAIT,
		S_FIN_EMIT
	} state_t;

	typedef struct packed {
		logic        present;
		logic [31:0] value;
	} lane_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
		logic [6:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

[rtl/core/idli_div.sv]
// Shared restoring divider, one quotient bit per cycle, for the interpolator.
// Depends on idli_pkg for the request and response structs.
module idli_div (
	input  logic                clk,
	input  logic                arst_n,
	input  idli_pkg::div_req_t  req,
	output idli_pkg::div_rsp_t  rsp
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [64:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] quot_q;
	logic [64:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[63:0], num_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {1'b0, req.num >> req.steps};
			num_q  <= req.num << (7'd64 - req.steps);
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (fits) begin
				rem_q  <= rem_sh - {1'b0, den_q};
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[rtl/core/inverse_distance_lut_interpolator_unit.sv]
// Inverse distance weighting over a calibration table of records, Q16.16 fixed point.
// Write actions complete without leaving idle. A query uses the shared divider for each record in use,
// one quotient bit per cycle, and may use it once more per result at the end.
// One item is worked at a time; results leave one per strobe and cannot be stalled.
// Reset clears control, configuration and the per-row presence valid bits; the point
// and value memories are not cleared. Depends on idli_pkg and idli_div.
module inverse_distance_lut_interpolator_unit #(
	parameter int RECORDS = 64,
	parameter int PARAMS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [5:0]         record_index,
	input  logic [2:0]         param_index,
	input  logic [31:0]        frequency,
	input  logic [31:0]        amplitude,
	input  logic signed [31:0] param_value,
	input  logic               param_present,
	input  logic signed [4:0]  voice_select,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data,
	output logic               result_strobe,
	output logic [2:0]         out_param,
	output logic signed [31:0] out_value,
	output logic signed [4:0]  out_voice,
	output logic               snapped,
	output logic               last
);

	localparam int AW  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int PW  = (PARAMS > 1) ? $clog2(PARAMS) : 1;
	localparam int CW  = AW + 1;
	localparam int PCW = PW + 1;
	localparam logic [10:0] REC_LIM = 11'(RECORDS);

	idli_pkg::state_t   state_q, state_d;
	idli_pkg::div_req_t div_req;
	idli_pkg::div_rsp_t div_rsp;

	logic [63:0]          pmem [RECORDS];
	idli_pkg::lane_t      vmem [RECORDS][PARAMS];
	logic [63:0]          prow_q;
	idli_pkg::lane_t      vrow_q [PARAMS];
	logic [RECORDS-1:0]   row_valid_q;

	logic                 enable_q;
	logic [6:0]           count_q;
	logic [31:0]          f_q, a_q;
	logic signed [4:0]    voice_q;
	logic [CW-1:0]        r_q;
	logic [PCW-1:0]       p_q;
	logic [3:0]           k_q;
	logic [30:0]          nf_q, na_q;
	logic [61:0]          sq_q, sq2_s1, d2_q;
	logic [31:0]          w_q;
	logic signed [63:0]   prod_s1;
	logic signed [63:0]   sums_q [PARAMS];
	logic [63:0]          tot_q [PARAMS];
	logic [31:0]          qmag_q;
	logic                 fsat_q;

	logic                 strobe_q, snap_q, last_q;
	logic [2:0]           oparam_q;
	logic signed [31:0]   oval_q;

	logic                 accept, rec_ok, par_ok;
	logic [10:0]          n_lim;
	logic [AW-1:0]        r_idx, wr_addr;
	logic [PW-1:0]        p_idx;
	logic [31:0]          ptf, pta, diff_f, diff_a;
	logic [32:0]          sum_f, sum_a;
	logic                 f_div, a_div;
	logic [PARAMS-1:0]    mask_pres, mask_nz;
	logic                 pres, higher_pres, higher_nz, last_k, p_end, r_end;
	logic                 is_snap, is_wsat;
	logic signed [63:0]   s_cur, s_add;
	logic [63:0]          abs_s;
	logic                 fin_fit, s_neg, s_ovf;
	logic signed [64:0]   prod_full;
	logic signed [31:0]   fin_val;
	logic                 emit_snap, emit_fin, stop_snap, stop_fin;

	assign accept    = start && !busy;
	assign busy      = (state_q != idli_pkg::S_IDLE) || strobe_q;
	assign cfg_ready = 1'b1;
	assign rec_ok    = 11'(record_index) < REC_LIM;
	assign par_ok    = 7'(param_index) < 7'(PARAMS);
	assign wr_addr   = AW'(record_index);
	assign n_lim     = (11'(count_q) > REC_LIM) ? REC_LIM : 11'(count_q);
	assign r_idx     = r_q[AW-1:0];
	assign p_idx     = p_q[PW-1:0];

	assign ptf    = prow_q[63:32];
	assign pta    = prow_q[31:0];
	assign diff_f = (f_q >= ptf) ? f_q - ptf : ptf - f_q;
	assign diff_a = (a_q >= pta) ? a_q - pta : pta - a_q;
	assign sum_f  = {1'b0, f_q} + {1'b0, ptf};
	assign sum_a  = {1'b0, a_q} + {1'b0, pta};
	assign f_div  = sum_f > idli_pkg::SUM_EPS;
	assign a_div  = sum_a > idli_pkg::SUM_EPS;

	always_comb begin
		for (int l = 0; l < PARAMS; l++) begin
			mask_pres[l] = vrow_q[l].present && row_valid_q[r_idx];
			mask_nz[l]   = tot_q[l] != 64'd0;
		end
	end

	assign pres        = mask_pres[p_idx];
	assign higher_pres = (mask_pres >> (p_q + PCW'(1))) != '0;
	assign higher_nz   = (mask_nz >> (p_q + PCW'(1))) != '0;
	assign last_k      = k_q == idli_pkg::LAST_SLOT;
	assign p_end       = p_q == PCW'(PARAMS - 1);
	assign r_end       = (11'(r_q) + 11'd1) == n_lim;
	assign is_snap     = d2_q <= idli_pkg::SNAP_D2;
	assign is_wsat     = d2_q <= idli_pkg::W_SAT_D2;

	assign s_cur   = sums_q[p_idx];
	assign s_add   = s_cur + prod_s1;
	assign s_ovf   = (s_cur[63] == prod_s1[63]) && (s_add[63] != s_cur[63]);
	assign s_neg   = s_cur[63];
	assign abs_s   = s_neg ? 64'(-s_cur) : 64'(s_cur);
	assign fin_fit = (abs_s >> 32) < tot_q[p_idx];

	assign prod_full = $signed(vrow_q[p_idx].value) * $signed({1'b0, w_q});

	always_comb begin
		if (fsat_q) begin
			fin_val = s_neg ? idli_pkg::S32_MIN : idli_pkg::S32_MAX;
		end else if (s_neg) begin
			fin_val = (qmag_q > 32'h8000_0000) ? idli_pkg::S32_MIN : $signed(-qmag_q);
		end else begin
			fin_val = (qmag_q > 32'h7FFF_FFFF) ? idli_pkg::S32_MAX : $signed(qmag_q);
		end
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = {2'b00, diff_f, 30'd0};
		div_req.den   = 64'(sum_f);
		div_req.steps = idli_pkg::STEPS_NORM;
		case (state_q)
			idli_pkg::S_NF_GO: begin
				div_req.start = f_div;
			end
			idli_pkg::S_NA_GO: begin
				div_req.start = a_div;
				div_req.num   = {2'b00, diff_a, 30'd0};
				div_req.den   = 64'(sum_a);
			end
			idli_pkg::S_W_GO: begin
				div_req.start = !is_snap && !is_wsat;
				div_req.num   = idli_pkg::WEIGHT_NUM;
				div_req.den   = 64'(d2_q);
				div_req.steps = idli_pkg::STEPS_WEIGHT;
			end
			idli_pkg::S_FIN: begin
				div_req.start = mask_nz[p_idx] && fin_fit;
				div_req.num   = abs_s;
				div_req.den   = tot_q[p_idx];
				div_req.steps = idli_pkg::STEPS_FINAL;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	idli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign emit_snap = (state_q == idli_pkg::S_SNAP) && pres;
	assign emit_fin  = state_q == idli_pkg::S_FIN_EMIT;
	assign stop_snap = p_end || (pres && (last_k || !higher_pres));
	assign stop_fin  = p_end || last_k || !higher_nz;

	always_comb begin
		state_d = state_q;
		case (state_q)
			idli_pkg::S_IDLE: begin
				if (accept && action == idli_pkg::ACT_QUERY && enable_q && n_lim != 11'd0) begin
					state_d = idli_pkg::S_READ;
				end
			end
			idli_pkg::S_READ: state_d = idli_pkg::S_NF_GO;
			idli_pkg::S_NF_GO: state_d = f_div ? idli_pkg::S_NF_WAIT : idli_pkg::S_NA_GO;
			idli_pkg::S_NF_WAIT: begin
				if (div_rsp.done) begin
					state_d = idli_pkg::S_NA_GO;
				end
			end
			idli_pkg::S_NA_GO: state_d = a_div ? idli_pkg::S_NA_WAIT : idli_pkg::S_SQ_F;
			idli_pkg::S_NA_WAIT: begin
				if (div_rsp.done) begin
					state_d = idli_pkg::S_SQ_F;
				end
			end
			idli_pkg::S_SQ_F: state_d = idli_pkg::S_SQ_A;
			idli_pkg::S_SQ_A: state_d = idli_pkg::S_D2;
			idli_pkg::S_D2: state_d = idli_pkg::S_W_GO;
			idli_pkg::S_W_GO: begin
				if (is_snap) begin
					state_d = idli_pkg::S_SNAP;
				end else if (is_wsat) begin
					state_d = idli_pkg::S_MUL;
				end else begin
					state_d = idli_pkg::S_W_WAIT;
				end
			end
			idli_pkg::S_W_WAIT: begin
				if (div_rsp.done) begin
					state_d = idli_pkg::S_MUL;
				end
			end
			idli_pkg::S_MUL, idli_pkg::S_ADD: begin
				if (state_q == idli_pkg::S_MUL && pres) begin
					state_d = idli_pkg::S_ADD;
				end else if (!p_end) begin
					state_d = idli_pkg::S_MUL;
				end else if (r_end) begin
					state_d = idli_pkg::S_FIN;
				end else begin
					state_d = idli_pkg::S_READ;
				end
			end
			idli_pkg::S_SNAP: begin
				if (stop_snap) begin
					state_d = idli_pkg::S_IDLE;
				end
			end
			idli_pkg::S_FIN: begin
				if (!mask_nz[p_idx]) begin
					state_d = p_end ? idli_pkg::S_IDLE : idli_pkg::S_FIN;
				end else if (fin_fit) begin
					state_d = idli_pkg::S_FIN_WAIT;
				end else begin
					state_d = idli_pkg::S_FIN_EMIT;
				end
			end
			idli_pkg::S_FIN_WAIT: begin
				if (div_rsp.done) begin
					state_d = idli_pkg::S_FIN_EMIT;
				end
			end
			idli_pkg::S_FIN_EMIT: state_d = stop_fin ? idli_pkg::S_IDLE : idli_pkg::S_FIN;
			default: state_d = idli_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idli_pkg::S_IDLE;
			enable_q    <= 1'b0;
			count_q     <= '0;
			row_valid_q <= '0;
			strobe_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit_snap || emit_fin;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					idli_pkg::CFG_IDX_ENABLE: enable_q <= cfg_data[0];
					idli_pkg::CFG_IDX_COUNT:  count_q  <= cfg_data;
					default: enable_q <= enable_q;
				endcase
			end
			if (accept && action == idli_pkg::ACT_WR_PARAM && rec_ok && par_ok) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == idli_pkg::ACT_WR_POINT && rec_ok) begin
			pmem[wr_addr] <= {frequency, amplitude};
		end
		if (accept && action == idli_pkg::ACT_WR_PARAM && rec_ok && par_ok) begin
			for (int l = 0; l < PARAMS; l++) begin
				if (7'(l) == 7'(param_index)) begin
					vmem[wr_addr][l] <= {param_present, param_value};
				end else if (!row_valid_q[wr_addr]) begin
					vmem[wr_addr][l] <= '0;
				end
			end
		end
		prow_q <= pmem[r_idx];
		vrow_q <= vmem[r_idx];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			idli_pkg::S_IDLE: begin
				if (accept && action == idli_pkg::ACT_QUERY) begin
					f_q     <= frequency;
					a_q     <= amplitude;
					voice_q <= voice_select;
					r_q     <= '0;
					for (int l = 0; l < PARAMS; l++) begin
						sums_q[l] <= '0;
						tot_q[l]  <= '0;
					end
				end
			end
			idli_pkg::S_NF_GO: begin
				if (!f_div) begin
					nf_q <= '0;
				end
			end
			idli_pkg::S_NF_WAIT: begin
				if (div_rsp.done) begin
					nf_q <= div_rsp.quot[30:0];
				end
			end
			idli_pkg::S_NA_GO: begin
				if (!a_div) begin
					na_q <= '0;
				end
			end
			idli_pkg::S_NA_WAIT: begin
				if (div_rsp.done) begin
					na_q <= div_rsp.quot[30:0];
				end
			end
			idli_pkg::S_SQ_F: sq_q <= nf_q * nf_q;
			idli_pkg::S_SQ_A: sq2_s1 <= na_q * na_q;
			idli_pkg::S_D2: d2_q <= sq_q + sq2_s1;
			idli_pkg::S_W_GO: begin
				p_q <= '0;
				k_q <= '0;
				if (is_wsat) begin
					w_q <= idli_pkg::WEIGHT_MAX;
				end
			end
			idli_pkg::S_W_WAIT: begin
				if (div_rsp.done) begin
					w_q <= div_rsp.quot[31:0];
				end
			end
			idli_pkg::S_MUL, idli_pkg::S_ADD: begin
				if (state_q == idli_pkg::S_MUL) begin
					prod_s1 <= prod_full[63:0];
				end else begin
					sums_q[p_idx] <= s_ovf ? (prod_s1[63] ? idli_pkg::S64_MIN : idli_pkg::S64_MAX)
					                       : s_add;
					tot_q[p_idx]  <= tot_q[p_idx] + 64'(w_q);
				end
				if (state_q == idli_pkg::S_ADD || !pres) begin
					if (!p_end) begin
						p_q <= p_q + PCW'(1);
					end else begin
						p_q <= '0;
						k_q <= '0;
						r_q <= r_q + CW'(1);
					end
				end
			end
			idli_pkg::S_SNAP: begin
				if (pres) begin
					oparam_q <= 3'(p_q);
					oval_q   <= $signed(vrow_q[p_idx].value);
					snap_q   <= 1'b1;
					last_q   <= last_k || !higher_pres;
					k_q      <= k_q + 4'd1;
				end
				p_q <= p_q + PCW'(1);
			end
			idli_pkg::S_FIN: begin
				fsat_q <= !fin_fit;
				if (!mask_nz[p_idx]) begin
					p_q <= p_q + PCW'(1);
				end
			end
			idli_pkg::S_FIN_WAIT: begin
				if (div_rsp.done) begin
					qmag_q <= div_rsp.quot[31:0];
				end
			end
			idli_pkg::S_FIN_EMIT: begin
				oparam_q <= 3'(p_q);
				oval_q   <= fin_val;
				snap_q   <= 1'b0;
				last_q   <= stop_fin;
				k_q      <= k_q + 4'd1;
				p_q      <= p_q + PCW'(1);
			end
			default: begin
				fsat_q <= fsat_q;
			end
		endcase
	end

	assign result_strobe = strobe_q;
	assign out_param     = oparam_q;
	assign out_value     = oval_q;
	assign out_voice     = voice_q;
	assign snapped       = snap_q;
	assign last          = last_q;

endmodule

[rtl/core/idli_checker.sv]
// Port level checks of the interpolator unit and the bind that attaches them.
// Depends on the top level's ports only.
module idli_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_strobe,
	input logic last
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result beat seen while the unit reports idle");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_strobe)
		else $error("result beat in the cycle right after an accepted item");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result beat directly after the final beat of a query");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("unit became busy without an accepted item");

endmodule

bind inverse_distance_lut_interpolator_unit idli_checker u_idli_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.last          (last)
);

[bench/testbench.sv]
// Self-checking bench for inverse_distance_lut_interpolator_unit: a directed table, then random
// record loads, parameter writes and queries, checked against an in-bench fixed point predictor.
// Depends on idli_pkg and the RTL of the unit.
module testbench;

	localparam int NREC = 64;
	localparam int NPAR = 8;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		idli_pkg::action_t  act;
		logic [5:0]         rec;
		logic [2:0]         par;
		logic [31:0]        f;
		logic [31:0]        a;
		logic signed [31:0] val;
		logic               pres;
		logic signed [4:0]  voice;
	} cmd_t;

	typedef struct {
		logic [2:0]         par;
		logic signed [31:0] value;
		logic signed [4:0]  voice;
		logic               snap;
		logic               last;
	} res_t;

	typedef struct {
		bit         is_cfg;
		logic       cfg_i;
		logic [6:0] cfg_d;
		cmd_t       c;
		int         exp_n;
		res_t       exp_r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = 2'd0;
	logic [5:0] record_index = 6'd0;
	logic [2:0] param_index = 3'd0;
	logic [31:0] frequency = 32'd0;
	logic [31:0] amplitude = 32'd0;
	logic signed [31:0] param_value = 32'sd0;
	logic param_present = 1'b0;
	logic signed [4:0] voice_select = 5'sd0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = 7'd0;
	logic result_strobe;
	logic [2:0] out_param;
	logic signed [31:0] out_value;
	logic signed [4:0] out_voice;
	logic snapped;
	logic last;

	inverse_distance_lut_interpolator_unit #(.RECORDS(NREC), .PARAMS(NPAR)) u_top (.*);

	always #10 clk = ~clk;

	logic model_en;
	logic [6:0] model_cnt;
	logic [31:0] pt_freq[NREC];
	logic [31:0] pt_amp[NREC];
	logic signed [31:0] rec_val[NREC][NPAR];
	logic rec_pres[NREC][NPAR];
	res_t interp_out[$];
	res_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	function automatic longint unsigned norm_diff(input logic [31:0] x, input logic [31:0] y);
		longint unsigned s;
		longint unsigned d;
		s = longint'(x) + longint'(y);
		d = (x > y) ? longint'(x - y) : longint'(y - x);
		if (s <= 6)
			return 0;
		return (d << 30) / s;
	endfunction

	function automatic longint sat_add(input longint x, input longint y);
		if (y > 0 && x > idli_pkg::S64_MAX - y)
			return idli_pkg::S64_MAX;
		if (y < 0 && x < idli_pkg::S64_MIN - y)
			return idli_pkg::S64_MIN;
		return x + y;
	endfunction

	task automatic interpolate(input cmd_t c);
		int n;
		longint unsigned nf;
		longint unsigned na;
		longint unsigned d2;
		longint unsigned w;
		longint q;
		longint sums[NPAR];
		longint unsigned tots[NPAR];
		bit near;
		res_t item;
		interp_out.delete();
		near = 0;
		case (c.act)
			idli_pkg::ACT_WR_POINT: begin
				pt_freq[c.rec] = c.f;
				pt_amp[c.rec] = c.a;
			end
			idli_pkg::ACT_WR_PARAM: begin
				rec_val[c.rec][c.par] = c.val;
				rec_pres[c.rec][c.par] = c.pres;
			end
			idli_pkg::ACT_QUERY: begin
				if (model_en && model_cnt != 0) begin
					n = (model_cnt > NREC) ? NREC : model_cnt;
					for (int p = 0; p < NPAR; p++) begin
						sums[p] = 0;
						tots[p] = 0;
					end
					for (int r = 0; r < n; r++) begin
						nf = norm_diff(c.f, pt_freq[r]);
						na = norm_diff(c.a, pt_amp[r]);
						d2 = nf * nf + na * na;
						if (d2 <= idli_pkg::SNAP_D2) begin
							for (int p = 0; p < NPAR; p++)
								if (rec_pres[r][p]) begin
									item = '{3'(p), rec_val[r][p], c.voice, 1'b1, 1'b0};
									interp_out.insert(interp_out.size(), item);
								end
							near = 1;
							break;
						end
						w = idli_pkg::WEIGHT_NUM / d2;
						if (w > idli_pkg::WEIGHT_MAX)
							w = idli_pkg::WEIGHT_MAX;
						for (int p = 0; p < NPAR; p++)
							if (rec_pres[r][p]) begin
								sums[p] = sat_add(sums[p], longint'(rec_val[r][p]) * longint'(w));
								tots[p] += w;
							end
					end
					if (!near)
						for (int p = 0; p < NPAR; p++)
							if (tots[p] > 0) begin
								q = sums[p] / longint'(tots[p]);
								if (q > idli_pkg::S32_MAX)
									q = idli_pkg::S32_MAX;
								if (q < idli_pkg::S32_MIN)
									q = idli_pkg::S32_MIN;
								item = '{3'(p), q[31:0], c.voice, 1'b0, 1'b0};
								interp_out.insert(interp_out.size(), item);
							end
					if (interp_out.size() > 0)
						interp_out[interp_out.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else if (result_strobe) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with none expected");
			end else begin
				e = pending_results.pop_front();
				if (out_param !== e.par || out_value !== e.value || out_voice !== e.voice ||
						snapped !== e.snap || last !== e.last)
					report_mismatch($sformatf(
						"got p%0d v%h vo%0d s%0d l%0d, want p%0d v%h vo%0d s%0d l%0d",
						out_param, out_value, out_voice, snapped, last,
						e.par, e.value, e.voice, e.snap, e.last));
			end
		end
	end

	task automatic send_cmd(input cmd_t c, input int exp_n, input res_t exp_r);
		start <= 1'b1;
		action <= c.act;
		record_index <= c.rec;
		param_index <= c.par;
		frequency <= c.f;
		amplitude <= c.a;
		param_value <= c.val;
		param_present <= c.pres;
		voice_select <= c.voice;
		do @(posedge clk); while (busy);
		interpolate(c);
		if (exp_n < 0) begin
			foreach (interp_out[i])
				pending_results.insert(pending_results.size(), interp_out[i]);
		end else if (exp_n > 0) begin
			pending_results.insert(pending_results.size(), exp_r);
		end
		if (!quiet && $urandom_range(99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == idli_pkg::CFG_IDX_ENABLE)
			model_en = data[0];
		else
			model_cnt = data;
		@(posedge clk);
	endtask

	function automatic row_t row_cmd(input idli_pkg::action_t act, input logic [5:0] rec,
			input logic [2:0] par, input logic [31:0] f, input logic [31:0] a,
			input logic [31:0] val, input logic pres, input logic signed [4:0] voice,
			input int exp_n, input logic [2:0] exp_par, input logic [31:0] exp_val);
		row_t r;
		r.is_cfg = 0;
		r.cfg_i = 1'b0;
		r.cfg_d = 7'd0;
		r.c = '{act, rec, par, f, a, val, pres, voice};
		r.exp_n = exp_n;
		r.exp_r = '{exp_par, exp_val, voice, 1'b1, 1'b1};
		return r;
	endfunction

	function automatic row_t row_cfg(input logic idx, input logic [6:0] data);
		row_t r;
		r = row_cmd(idli_pkg::ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.is_cfg = 1;
		r.cfg_i = idx;
		r.cfg_d = data;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return $urandom_range(0, 8);
			2: return $urandom_range(0, 32'h0010_0000);
			default: return $urandom;
		endcase
	endfunction

	row_t directed[$];
	int counts[9] = '{1, 3, 8, 0, 5, 64, 2, 127, 6};

	initial begin
		cmd_t c;
		res_t none;
		int live;
		int k;
		model_en = 1'b0;
		model_cnt = 7'd0;
		foreach (rec_pres[i, j]) begin
			rec_pres[i][j] = 1'b0;
			rec_val[i][j] = 32'sd0;
		end
		foreach (pt_freq[i]) begin
			pt_freq[i] = 32'd0;
			pt_amp[i] = 32'd0;
		end
		none = '{0, 0, 0, 0, 0};
		directed = '{
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h0, 32'h0, 0, 0, -5'sd1, 0, 0, 0),
			row_cmd(idli_pkg::ACT_NONE, 6'd63, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				32'hFFFF_FFFF, 1, 15, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_POINT, 0, 0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_POINT, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_POINT, 2, 0, 32'h03E8_0000, 32'h0000_8000, 0, 0, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_PARAM, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_PARAM, 1, 7, 0, 0, 32'h8000_0000, 1, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_PARAM, 2, 3, 0, 0, 32'h0001_0000, 1, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_PARAM, 2, 5, 0, 0, 32'hFFFF_FFFB, 1, 0, 0, 0, 0),
			row_cfg(idli_pkg::CFG_IDX_ENABLE, 7'd1),
			row_cfg(idli_pkg::CFG_IDX_COUNT, 7'd3),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h0, 32'h0, 0, 0, -5'sd1, 1, 0, 32'h7FFF_FFFF),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 15, 1, 7,
				32'h8000_0000),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h03E8_0000, 32'h0000_8000, 0, 0, 0, -1, 0, 0),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h0080_0000, 32'h0000_4000, 0, 0, 3, -1, 0, 0),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h1, 32'h1, 0, 0, 5, 1, 0, 32'h7FFF_FFFF),
			row_cmd(idli_pkg::ACT_WR_PARAM, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_WR_PARAM, 2, 5, 0, 0, 0, 0, 0, 0, 0, 0),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h03E8_0000, 32'h0000_8000, 0, 0, 7, 0, 0, 0),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h1, 0, 0, -5'sd16, -1, 0, 0),
			row_cfg(idli_pkg::CFG_IDX_ENABLE, 7'd0),
			row_cmd(idli_pkg::ACT_QUERY, 0, 0, 32'h1234, 32'h5678, 0, 0, 9, 0, 0, 0),
			row_cfg(idli_pkg::CFG_IDX_ENABLE, 7'd1)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				wait_idle();
				write_reg(directed[i].cfg_i, directed[i].cfg_d);
			end else begin
				send_cmd(directed[i].c, directed[i].exp_n, directed[i].exp_r);
			end
		end

		for (int r = 0; r < NREC; r++) begin
			c = '{idli_pkg::ACT_WR_POINT, r, $urandom, rand_word(), rand_word(), $urandom,
				$urandom, $urandom};
			send_cmd(c, -1, none);
		end

		for (int ph = 0; ph < 9; ph++) begin
			wait_idle();
			write_reg(idli_pkg::CFG_IDX_ENABLE, (ph == 3) ? 7'd0 : 7'd1);
			write_reg(idli_pkg::CFG_IDX_COUNT, 7'(counts[ph]));
			quiet = (ph == 4 || ph == 5);
			live = (counts[ph] == 0) ? 1 : ((counts[ph] > NREC) ? NREC : counts[ph]);
			for (int i = 0; i < 25; i++) begin
				c = '{idli_pkg::action_t'($urandom_range(3)), $urandom, $urandom, rand_word(),
					rand_word(), rand_word(), $urandom, $urandom};
				k = $urandom_range(99);
				if (k < 55) begin
					c.act = idli_pkg::ACT_QUERY;
					k = $urandom_range(live - 1);
					case ($urandom_range(4))
						0, 1: begin
							c.f = pt_freq[k];
							c.a = pt_amp[k];
						end
						2: begin
							c.f = pt_freq[k] + $urandom_range(0, 3);
							c.a = pt_amp[k] - $urandom_range(0, 3);
						end
						default: ;
					endcase
				end else if (k < 85) begin
					c.act = idli_pkg::ACT_WR_PARAM;
					c.rec = $urandom_range(live - 1);
					c.pres = ($urandom_range(9) < 8);
				end else if (k < 95) begin
					c.act = idli_pkg::ACT_WR_POINT;
				end else begin
					c.act = idli_pkg::ACT_NONE;
				end
				send_cmd(c, -1, none);
			end
		end
		quiet = 0;

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
